// ===== rtl/lnbt_pkg.sv =====
// Shared types, widths, codes and sigmoid table functions for the neuron batch trainer.
`default_nettype none

package lnbt_pkg;

    localparam int FEATURE_COUNT       = 2;
    localparam int SIG_ENTRIES_DEFAULT = 256;

    localparam int IN_W    = 16;
    localparam int W_W     = 32;
    localparam int RATE_W  = 16;
    localparam int P_W     = 13;
    localparam int D_W     = 17;
    localparam int S_W     = 11;
    localparam int SQ_W    = 23;
    localparam int E_W     = 28;
    localparam int ER_W    = 45;
    localparam int PROD_W  = 48;
    localparam int Z_W     = 50;
    localparam int UPD_W   = 60;
    localparam int TALLY_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [15:0] LEARN_RATE_RESET = 16'd655;

    localparam logic OP_TRAIN = 1'b0;
    localparam logic OP_LOAD  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEARN_RATE,
        CFG_INIT_WEIGHT_A,
        CFG_INIT_WEIGHT_B,
        CFG_INIT_BIAS
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_INDEX,
        ST_LOOK,
        ST_ERR,
        ST_GRAD,
        ST_SCALE,
        ST_UPD,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic capture;
        logic mul;
        logic sum;
        logic index;
        logic look;
        logic err;
        logic grad;
        logic scale;
        logic upd;
        logic commit;
        logic last;
    } ctl_t;

    function automatic logic signed [W_W-1:0] sat32(input logic signed [W_W+1:0] v);
        if (v > 34'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        else if (v < -34'sd2147483648)
        begin
            return 32'sh80000000;
        end
        else
        begin
            return v[W_W-1:0];
        end
    endfunction

    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 64'd0;
        rem = 64'd0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], num[i]};
            if (rem >= den)
            begin
                rem = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [P_W-1:0] sig_entry(input int k, input int n);
        longint signed   off;
        longint signed   acc;
        longint unsigned a;
        longint unsigned g;
        longint unsigned t;
        longint unsigned e;
        longint unsigned d;
        longint unsigned q;
        off = 2 * longint'(k) + 1 - longint'(n);
        a = (off < 0) ? -off : off;
        g = udiv64(a << 31, $unsigned(longint'(n)));
        t = 64'd1 << 31;
        acc = $signed(t);
        for (int j = 1; j <= 24; j++)
        begin
            t = udiv64((t * g) >> 31, $unsigned(longint'(j)));
            if (j[0])
            begin
                acc = acc - $signed(t);
            end
            else
            begin
                acc = acc + $signed(t);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        if (acc > (64'sd1 <<< 31))
        begin
            acc = 64'sd1 <<< 31;
        end
        e = $unsigned(acc);
        for (int r = 0; r < 3; r++)
        begin
            e = (e * e) >> 31;
        end
        d = (64'd1 << 31) + e;
        q = udiv64((64'd1 << 43) + (d >> 1), d);
        if (off >= 0)
        begin
            return q[P_W-1:0];
        end
        else
        begin
            return P_W'(64'd4096 - q);
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lnbt_lane.sv =====
// One feature lane: holds its weights, forms the weighted feature and the weight update.
`default_nettype none

module lnbt_lane (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lnbt_pkg::ctl_t                       ctl,
    input  logic signed [lnbt_pkg::IN_W-1:0]     feature,
    input  logic signed [lnbt_pkg::W_W-1:0]      init_weight,
    input  logic signed [lnbt_pkg::ER_W-1:0]     er,
    output logic signed [lnbt_pkg::PROD_W-1:0]   prod,
    output logic signed [lnbt_pkg::W_W-1:0]      pend_sat
);
    import lnbt_pkg::*;

    logic signed [IN_W-1:0]   x_reg, x_next;
    logic signed [W_W-1:0]    weight_reg, weight_next;
    logic signed [W_W-1:0]    pend_reg, pend_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [UPD_W-1:0]  upd_reg, upd_next;
    logic signed [W_W+1:0]    pend_sum;

    always_comb
    begin
        pend_sum = {{2{pend_reg[W_W-1]}}, pend_reg}
                 + {{10{upd_reg[UPD_W-1]}}, upd_reg[UPD_W-1:36]};
        pend_sat = sat32(pend_sum);

        x_next      = x_reg;
        prod_next   = prod_reg;
        upd_next    = upd_reg;
        weight_next = weight_reg;
        pend_next   = pend_reg;

        if (ctl.capture)
        begin
            x_next = feature;
        end
        if (ctl.mul)
        begin
            prod_next = PROD_W'(weight_reg) * PROD_W'(x_reg);
        end
        if (ctl.upd)
        begin
            upd_next = UPD_W'(er) * UPD_W'(x_reg);
        end
        if (ctl.load)
        begin
            weight_next = init_weight;
            pend_next   = init_weight;
        end
        else if (ctl.commit)
        begin
            pend_next = pend_sat;
            if (ctl.last)
            begin
                weight_next = pend_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= '0;
            pend_reg   <= '0;
        end
        else
        begin
            weight_reg <= weight_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        prod_reg <= prod_next;
        upd_reg  <= upd_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== rtl/lnbt_merge.sv =====
// Merging stage: sums the lanes, looks up the sigmoid, forms the error terms and the bias.
`default_nettype none

module lnbt_merge #(
    parameter int SIGMOID_ENTRIES = lnbt_pkg::SIG_ENTRIES_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lnbt_pkg::ctl_t                       ctl,
    input  logic signed [lnbt_pkg::IN_W-1:0]     target,
    input  logic signed [lnbt_pkg::PROD_W-1:0]   lane_prod [lnbt_pkg::FEATURE_COUNT],
    input  logic [lnbt_pkg::RATE_W-1:0]          learn_rate,
    input  logic signed [lnbt_pkg::W_W-1:0]      init_bias,
    output logic signed [lnbt_pkg::ER_W-1:0]     er,
    output logic signed [lnbt_pkg::W_W-1:0]      bias_sat,
    output logic [lnbt_pkg::W_W-1:0]             err_sat,
    output logic [lnbt_pkg::TALLY_W-1:0]         tally_sat
);
    import lnbt_pkg::*;

    localparam int IDX_W = $clog2(SIGMOID_ENTRIES);
    localparam int SC_W  = 33 + IDX_W;

    logic [P_W-1:0] sig_rom [SIGMOID_ENTRIES];

    for (genvar k = 0; k < SIGMOID_ENTRIES; k++)
    begin : g_rom
        localparam logic [P_W-1:0] ENTRY = sig_entry(k, SIGMOID_ENTRIES);
        assign sig_rom[k] = ENTRY;
    end

    logic signed [IN_W-1:0]  t_reg, t_next;
    logic signed [Z_W-1:0]   z_reg, z_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [P_W-1:0]          p_reg, p_next;
    logic signed [D_W-1:0]   d_reg, d_next;
    logic [S_W-1:0]          s_reg, s_next;
    logic [SQ_W-1:0]         sq_reg, sq_next;
    logic signed [E_W-1:0]   e_reg, e_next;
    logic signed [ER_W-1:0]  er_reg, er_next;
    logic signed [20:0]      bdelta_reg, bdelta_next;
    logic signed [W_W-1:0]   bias_now_reg, bias_now_next;
    logic signed [W_W-1:0]   pend_bias_reg, pend_bias_next;
    logic [W_W-1:0]          err_reg, err_next;
    logic [TALLY_W-1:0]      tally_reg, tally_next;

    logic signed [Z_W-1:0]   z_sum;
    logic [Z_W-32:0]         z_hi;
    logic [31:0]             z_u;
    logic [SC_W-1:0]         scaled;
    logic signed [D_W-1:0]   p_ext;
    logic signed [D_W-1:0]   t_ext;
    logic [P_W-1:0]          p_comp;
    logic [2*P_W-1:0]        ps;
    logic signed [2*D_W-1:0] sq_full;
    logic signed [E_W:0]     ds;
    logic signed [RATE_W+1:0] nrate;
    logic signed [W_W+1:0]   bias_sum;
    logic [W_W:0]            err_sum;

    always_comb
    begin
        z_sum = {{(Z_W-W_W-12){bias_now_reg[W_W-1]}}, bias_now_reg, 12'b0};
        for (int i = 0; i < FEATURE_COUNT; i++)
        begin
            z_sum = z_sum + {{(Z_W-PROD_W){lane_prod[i][PROD_W-1]}}, lane_prod[i]};
        end

        z_hi   = z_reg[Z_W-1:31];
        z_u    = {~z_reg[31], z_reg[30:0]};
        scaled = SC_W'(z_u) * SC_W'(SIGMOID_ENTRIES);

        p_ext   = {4'b0, p_reg};
        t_ext   = {t_reg[IN_W-1], t_reg};
        p_comp  = 13'd4096 - p_reg;
        ps      = (2*P_W)'(p_reg) * (2*P_W)'(p_comp);
        d_next  = d_reg;
        sq_full = (2*D_W)'(p_ext - t_ext) * (2*D_W)'(p_ext - t_ext);

        ds    = (E_W+1)'(d_reg) * (E_W+1)'($signed({1'b0, s_reg}));
        nrate = 18'sd0 - $signed({2'b00, learn_rate});

        bias_sum = {{2{pend_bias_reg[W_W-1]}}, pend_bias_reg}
                 + {{13{bdelta_reg[20]}}, bdelta_reg};
        bias_sat = sat32(bias_sum);
        err_sum  = {1'b0, err_reg} + {10'b0, sq_reg};
        err_sat  = err_sum[W_W] ? '1 : err_sum[W_W-1:0];
        tally_sat = (&tally_reg) ? tally_reg : tally_reg + 16'd1;

        t_next         = t_reg;
        z_next         = z_reg;
        idx_next       = idx_reg;
        p_next         = p_reg;
        s_next         = s_reg;
        sq_next        = sq_reg;
        e_next         = e_reg;
        er_next        = er_reg;
        bdelta_next    = bdelta_reg;
        bias_now_next  = bias_now_reg;
        pend_bias_next = pend_bias_reg;
        err_next       = err_reg;
        tally_next     = tally_reg;

        if (ctl.capture)
        begin
            t_next = target;
        end
        if (ctl.sum)
        begin
            z_next = z_sum;
        end
        if (ctl.index)
        begin
            if ((&z_hi) || (~|z_hi))
            begin
                idx_next = scaled[32 +: IDX_W];
            end
            else if (z_reg[Z_W-1])
            begin
                idx_next = '0;
            end
            else
            begin
                idx_next = IDX_W'(SIGMOID_ENTRIES - 1);
            end
        end
        if (ctl.look)
        begin
            p_next = sig_rom[idx_reg];
        end
        if (ctl.err)
        begin
            d_next  = p_ext - t_ext;
            s_next  = ps[22:12];
            sq_next = sq_full[30:8];
        end
        if (ctl.grad)
        begin
            e_next = {ds[E_W-2:0], 1'b0};
        end
        if (ctl.scale)
        begin
            er_next = ER_W'(e_reg) * ER_W'(nrate);
        end
        if (ctl.upd)
        begin
            bdelta_next = er_reg[ER_W-1:24];
        end
        if (ctl.load)
        begin
            bias_now_next  = init_bias;
            pend_bias_next = init_bias;
            err_next       = '0;
            tally_next     = '0;
        end
        else if (ctl.commit)
        begin
            pend_bias_next = bias_sat;
            err_next       = err_sat;
            tally_next     = tally_sat;
            if (ctl.last)
            begin
                bias_now_next = bias_sat;
                err_next      = '0;
                tally_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_now_reg  <= '0;
            pend_bias_reg <= '0;
            err_reg       <= '0;
            tally_reg     <= '0;
        end
        else
        begin
            bias_now_reg  <= bias_now_next;
            pend_bias_reg <= pend_bias_next;
            err_reg       <= err_next;
            tally_reg     <= tally_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg      <= t_next;
        z_reg      <= z_next;
        idx_reg    <= idx_next;
        p_reg      <= p_next;
        d_reg      <= d_next;
        s_reg      <= s_next;
        sq_reg     <= sq_next;
        e_reg      <= e_next;
        er_reg     <= er_next;
        bdelta_reg <= bdelta_next;
    end

    assign er = er_reg;

endmodule

`default_nettype wire

// ===== rtl/logistic_neuron_batch_trainer_unit.sv =====
// Top level of the sigmoid neuron batch trainer: configuration, sequencer, lanes and result register.
//
//   channel   direction  handshake            word
//   in        input      in_valid / in_stall  opcode, feature_a, feature_b, target, last_of_epoch
//   out       output     out_valid / out_stall weight_a_out, weight_b_out, bias_out,
//                                              error_total, samples_seen
//   cfg       input      cfg_wen              cfg_index, cfg_wdata
//
// A training word is accepted and then takes nine steps through the chain of
// registered multipliers (weighted sum, table index, p(1-p) and error, gradient, rate, update).
// A load word does not raise in_stall. Reset clears all weights and accumulators and sets the
// learning rate to 655. A stalled result holds the final commit of the next epoch-ending word
// until the result register is free; words in the middle of an epoch never wait on out_stall.
`default_nettype none

module logistic_neuron_batch_trainer_unit #(
    parameter int SIGMOID_ENTRIES = lnbt_pkg::SIG_ENTRIES_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 opcode,
    input  logic signed [lnbt_pkg::IN_W-1:0]     feature_a,
    input  logic signed [lnbt_pkg::IN_W-1:0]     feature_b,
    input  logic signed [lnbt_pkg::IN_W-1:0]     target,
    input  logic                                 last_of_epoch,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [lnbt_pkg::W_W-1:0]      weight_a_out,
    output logic signed [lnbt_pkg::W_W-1:0]      weight_b_out,
    output logic signed [lnbt_pkg::W_W-1:0]      bias_out,
    output logic [lnbt_pkg::W_W-1:0]             error_total,
    output logic [lnbt_pkg::TALLY_W-1:0]         samples_seen,
    input  logic                                 cfg_wen,
    input  logic [lnbt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lnbt_pkg::W_W-1:0]             cfg_wdata
);
    import lnbt_pkg::*;

    state_t state_reg, state_next;
    ctl_t   ctl;

    logic [RATE_W-1:0]      rate_reg, rate_next;
    logic signed [W_W-1:0]  init_a_reg, init_a_next;
    logic signed [W_W-1:0]  init_b_reg, init_b_next;
    logic signed [W_W-1:0]  init_bias_reg, init_bias_next;
    logic                   last_reg, last_next;

    logic                   out_valid_reg, out_valid_next;
    logic signed [W_W-1:0]  wa_out_reg, wa_out_next;
    logic signed [W_W-1:0]  wb_out_reg, wb_out_next;
    logic signed [W_W-1:0]  bias_out_reg, bias_out_next;
    logic [W_W-1:0]         err_out_reg, err_out_next;
    logic [TALLY_W-1:0]     tally_out_reg, tally_out_next;

    logic signed [IN_W-1:0]   feat [FEATURE_COUNT];
    logic signed [W_W-1:0]    init_w [FEATURE_COUNT];
    logic signed [PROD_W-1:0] lane_prod [FEATURE_COUNT];
    logic signed [W_W-1:0]    pend_sat [FEATURE_COUNT];
    logic signed [ER_W-1:0]   er;
    logic signed [W_W-1:0]    bias_sat;
    logic [W_W-1:0]           err_sat;
    logic [TALLY_W-1:0]       tally_sat;

    assign feat[0]   = feature_a;
    assign feat[1]   = feature_b;
    assign init_w[0] = init_a_reg;
    assign init_w[1] = init_b_reg;

    for (genvar i = 0; i < FEATURE_COUNT; i++)
    begin : g_lane
        lnbt_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .feature     (feat[i]),
            .init_weight (init_w[i]),
            .er          (er),
            .prod        (lane_prod[i]),
            .pend_sat    (pend_sat[i])
        );
    end

    lnbt_merge #(
        .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .target     (target),
        .lane_prod  (lane_prod),
        .learn_rate (rate_reg),
        .init_bias  (init_bias_reg),
        .er         (er),
        .bias_sat   (bias_sat),
        .err_sat    (err_sat),
        .tally_sat  (tally_sat)
    );

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == OP_LOAD)
                    begin
                        ctl.load = 1'b1;
                    end
                    else
                    begin
                        ctl.capture = 1'b1;
                        state_next  = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                ctl.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                ctl.sum    = 1'b1;
                state_next = ST_INDEX;
            end
            ST_INDEX:
            begin
                ctl.index  = 1'b1;
                state_next = ST_LOOK;
            end
            ST_LOOK:
            begin
                ctl.look   = 1'b1;
                state_next = ST_ERR;
            end
            ST_ERR:
            begin
                ctl.err    = 1'b1;
                state_next = ST_GRAD;
            end
            ST_GRAD:
            begin
                ctl.grad   = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                ctl.scale  = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                ctl.upd    = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!last_reg || !out_valid_reg || !out_stall)
                begin
                    ctl.commit = 1'b1;
                    ctl.last   = last_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rate_next      = rate_reg;
        init_a_next    = init_a_reg;
        init_b_next    = init_b_reg;
        init_bias_next = init_bias_reg;
        if (cfg_wen)
        begin
            case (cfg_index)
                CFG_LEARN_RATE:    rate_next      = cfg_wdata[RATE_W-1:0];
                CFG_INIT_WEIGHT_A: init_a_next    = cfg_wdata;
                CFG_INIT_WEIGHT_B: init_b_next    = cfg_wdata;
                CFG_INIT_BIAS:     init_bias_next = cfg_wdata;
                default:           rate_next      = rate_reg;
            endcase
        end

        last_next = ctl.capture ? last_of_epoch : last_reg;

        out_valid_next = out_valid_reg;
        wa_out_next    = wa_out_reg;
        wb_out_next    = wb_out_reg;
        bias_out_next  = bias_out_reg;
        err_out_next   = err_out_reg;
        tally_out_next = tally_out_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (ctl.last)
        begin
            out_valid_next = 1'b1;
            wa_out_next    = pend_sat[0];
            wb_out_next    = pend_sat[1];
            bias_out_next  = bias_sat;
            err_out_next   = err_sat;
            tally_out_next = tally_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rate_reg      <= LEARN_RATE_RESET;
            init_a_reg    <= '0;
            init_b_reg    <= '0;
            init_bias_reg <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rate_reg      <= rate_next;
            init_a_reg    <= init_a_next;
            init_b_reg    <= init_b_next;
            init_bias_reg <= init_bias_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wa_out_reg    <= wa_out_next;
        wb_out_reg    <= wb_out_next;
        bias_out_reg  <= bias_out_next;
        err_out_reg   <= err_out_next;
        tally_out_reg <= tally_out_next;
    end

    assign out_valid    = out_valid_reg;
    assign weight_a_out = wa_out_reg;
    assign weight_b_out = wb_out_reg;
    assign bias_out     = bias_out_reg;
    assign error_total  = err_out_reg;
    assign samples_seen = tally_out_reg;

endmodule

`default_nettype wire

// ===== rtl/lnbt_checker.sv =====
// Port-level checks for the neuron batch trainer and their binding to the top level.
`default_nettype none

module lnbt_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 opcode,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic signed [lnbt_pkg::W_W-1:0]      weight_a_out,
    input logic [lnbt_pkg::W_W-1:0]             error_total,
    input logic [lnbt_pkg::TALLY_W-1:0]         samples_seen
);
    import lnbt_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(weight_a_out) && $stable(error_total))
        else $error("Stalled result word changed or was dropped.");

    a_train_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && opcode == OP_TRAIN |=> in_stall)
        else $error("Training word did not occupy the datapath.");

    a_load_single: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && opcode == OP_LOAD |=> !in_stall)
        else $error("Load word held the input beyond one cycle.");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("Result word appeared without a training word in flight.");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> samples_seen != '0)
        else $error("Result word reports an empty epoch.");

endmodule

bind logistic_neuron_batch_trainer_unit lnbt_checker u_lnbt_checker (.*);

`default_nettype wire

// ===== dv/epoch_checker.sv =====
// Checker for the neuron batch trainer: predicts every epoch result and compares the outputs.
module epoch_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic                                 opcode,
    input  logic signed [lnbt_pkg::IN_W-1:0]     feature_a,
    input  logic signed [lnbt_pkg::IN_W-1:0]     feature_b,
    input  logic signed [lnbt_pkg::IN_W-1:0]     target,
    input  logic                                 last_of_epoch,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic signed [lnbt_pkg::W_W-1:0]      weight_a_out,
    input  logic signed [lnbt_pkg::W_W-1:0]      weight_b_out,
    input  logic signed [lnbt_pkg::W_W-1:0]      bias_out,
    input  logic [lnbt_pkg::W_W-1:0]             error_total,
    input  logic [lnbt_pkg::TALLY_W-1:0]         samples_seen,
    input  logic                                 cfg_wen,
    input  logic [lnbt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lnbt_pkg::W_W-1:0]             cfg_wdata,
    output int                                   errors,
    output int                                   epochs_open
);
    timeunit 1ns;
    timeprecision 1ps;

    import lnbt_pkg::*;

    localparam int     LUT_SIZE     = SIG_ENTRIES_DEFAULT;
    localparam longint Z_EDGE       = 64'sd2147483648;
    localparam int     REPORT_LINES = 40;

    typedef struct {
        logic signed [W_W-1:0] weight_a;
        logic signed [W_W-1:0] weight_b;
        logic signed [W_W-1:0] bias;
        logic [W_W-1:0]        err_sum;
        logic [TALLY_W-1:0]    count;
    } epoch_report_t;

    epoch_report_t         epochs_due[$];
    logic [P_W-1:0]        sigmoid_lut [LUT_SIZE];
    logic [RATE_W-1:0]     step_rate;
    logic signed [W_W-1:0] start_wa;
    logic signed [W_W-1:0] start_wb;
    logic signed [W_W-1:0] start_bias;
    logic signed [W_W-1:0] live_wa;
    logic signed [W_W-1:0] live_wb;
    logic signed [W_W-1:0] live_bias;
    logic signed [W_W-1:0] next_wa;
    logic signed [W_W-1:0] next_wb;
    logic signed [W_W-1:0] next_bias;
    logic [W_W-1:0]        err_sum;
    logic [TALLY_W-1:0]    tally;

    function automatic longint unsigned exp_decay(input longint unsigned g);
        longint unsigned term;
        longint unsigned e;
        longint          series;
        int              j;
        term = 64'd1 << 31;
        series = $signed(term);
        for (j = 1; j <= 24; j++)
        begin
            term = ((term * g) >> 31) / j;
            if (j % 2 == 1)
            begin
                series = series - $signed(term);
            end
            else
            begin
                series = series + $signed(term);
            end
        end
        if (series < 0)
        begin
            series = 0;
        end
        if (series > Z_EDGE)
        begin
            series = Z_EDGE;
        end
        e = $unsigned(series);
        repeat (3)
        begin
            e = (e * e) >> 31;
        end
        return e;
    endfunction

    function automatic void build_sigmoid_lut();
        longint          offset;
        longint unsigned span;
        longint unsigned den;
        longint unsigned q;
        int              k;
        for (k = 0; k < LUT_SIZE; k++)
        begin
            offset = 2 * k + 1 - LUT_SIZE;
            if (offset < 0)
            begin
                span = $unsigned(-offset);
            end
            else
            begin
                span = $unsigned(offset);
            end
            den = (64'd1 << 31) + exp_decay((span << 31) / LUT_SIZE);
            q = ((64'd1 << 43) + den / 2) / den;
            if (offset >= 0)
            begin
                sigmoid_lut[k] = P_W'(q);
            end
            else
            begin
                sigmoid_lut[k] = P_W'(64'd4096 - q);
            end
        end
    endfunction

    function automatic logic signed [W_W-1:0] saturate_q16(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[W_W-1:0];
    endfunction

    task automatic report(input string what);
        errors++;
        if (errors <= REPORT_LINES)
        begin
            $display("%0t ns: epoch result mismatch: %s", $time, what);
        end
    endtask

    task automatic absorb_sample(input logic signed [IN_W-1:0] fa,
                                 input logic signed [IN_W-1:0] fb,
                                 input logic signed [IN_W-1:0] tg,
                                 input logic last);
        longint          z;
        longint          idx;
        longint          p;
        longint          d;
        longint          s;
        longint          e;
        longint          rate;
        longint          xa;
        longint          xb;
        longint unsigned err;
        epoch_report_t   rpt;
        xa = longint'(fa);
        xb = longint'(fb);
        rate = longint'({48'd0, step_rate});
        z = longint'(live_bias) * 4096 + longint'(live_wa) * xa + longint'(live_wb) * xb;
        if (z < -Z_EDGE)
        begin
            idx = 0;
        end
        else if (z >= Z_EDGE)
        begin
            idx = LUT_SIZE - 1;
        end
        else
        begin
            idx = ((z + Z_EDGE) * LUT_SIZE) >>> 32;
        end
        if (idx > LUT_SIZE - 1)
        begin
            idx = LUT_SIZE - 1;
        end
        p = longint'(sigmoid_lut[idx]);
        d = p - longint'(tg);
        err = {32'd0, err_sum} + $unsigned((d * d) >>> 8);
        err_sum = (err > 64'hFFFFFFFF) ? 32'hFFFFFFFF : err[W_W-1:0];
        if (tally != 16'hFFFF)
        begin
            tally = tally + 16'd1;
        end
        s = (p * (4096 - p)) >>> 12;
        e = 2 * d * s;
        next_wa = saturate_q16(longint'(next_wa) + ((-(e * xa * rate)) >>> 36));
        next_wb = saturate_q16(longint'(next_wb) + ((-(e * xb * rate)) >>> 36));
        next_bias = saturate_q16(longint'(next_bias) + ((-(e * rate)) >>> 24));
        if (last)
        begin
            live_wa = next_wa;
            live_wb = next_wb;
            live_bias = next_bias;
            rpt.weight_a = live_wa;
            rpt.weight_b = live_wb;
            rpt.bias = live_bias;
            rpt.err_sum = err_sum;
            rpt.count = tally;
            epochs_due.push_back(rpt);
            err_sum = '0;
            tally = '0;
        end
    endtask

    task automatic check_result();
        epoch_report_t want;
        if (epochs_due.size() == 0)
        begin
            report("result word with no finished epoch");
            return;
        end
        want = epochs_due.pop_front();
        if (weight_a_out !== want.weight_a)
        begin
            report($sformatf("weight_a_out %0d, want %0d", weight_a_out, want.weight_a));
        end
        if (weight_b_out !== want.weight_b)
        begin
            report($sformatf("weight_b_out %0d, want %0d", weight_b_out, want.weight_b));
        end
        if (bias_out !== want.bias)
        begin
            report($sformatf("bias_out %0d, want %0d", bias_out, want.bias));
        end
        if (error_total !== want.err_sum)
        begin
            report($sformatf("error_total %0d, want %0d", error_total, want.err_sum));
        end
        if (samples_seen !== want.count)
        begin
            report($sformatf("samples_seen %0d, want %0d", samples_seen, want.count));
        end
    endtask

    initial
    begin
        build_sigmoid_lut();
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_rate = LEARN_RATE_RESET;
            start_wa = '0;
            start_wb = '0;
            start_bias = '0;
            live_wa = '0;
            live_wb = '0;
            live_bias = '0;
            next_wa = '0;
            next_wb = '0;
            next_bias = '0;
            err_sum = '0;
            tally = '0;
            epochs_due.delete();
            epochs_open <= 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_LEARN_RATE:    step_rate = cfg_wdata[RATE_W-1:0];
                    CFG_INIT_WEIGHT_A: start_wa = cfg_wdata;
                    CFG_INIT_WEIGHT_B: start_wb = cfg_wdata;
                    CFG_INIT_BIAS:     start_bias = cfg_wdata;
                    default:           ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (opcode == OP_LOAD)
                begin
                    live_wa = start_wa;
                    live_wb = start_wb;
                    live_bias = start_bias;
                    next_wa = start_wa;
                    next_wb = start_wb;
                    next_bias = start_bias;
                    err_sum = '0;
                    tally = '0;
                end
                else
                begin
                    absorb_sample(feature_a, feature_b, target, last_of_epoch);
                end
            end
            if (out_valid && !out_stall)
            begin
                check_result();
            end
            epochs_open <= epochs_due.size();
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the neuron batch trainer: clock, reset, training words and the verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lnbt_pkg::*;

    localparam int CLOCK_HALF    = 6;
    localparam int RESET_CYCLES  = 4;
    localparam int RANDOM_WORDS  = 1200;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 320;
    localparam int HOLD_WORDS    = 60;
    localparam int HOLD_PHASE    = 3;
    localparam int CYCLE_LIMIT   = 250000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    opcode = OP_TRAIN;
    logic signed [IN_W-1:0]  feature_a = '0;
    logic signed [IN_W-1:0]  feature_b = '0;
    logic signed [IN_W-1:0]  target = '0;
    logic                    last_of_epoch = 1'b0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [W_W-1:0]   weight_a_out;
    logic signed [W_W-1:0]   weight_b_out;
    logic signed [W_W-1:0]   bias_out;
    logic [W_W-1:0]          error_total;
    logic [TALLY_W-1:0]      samples_seen;
    logic                    cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [W_W-1:0]          cfg_wdata = '0;

    int     failures;
    int     epochs_open;
    int     words_sent = 0;
    int     gap_max = 0;
    int     burst_left = 0;
    bit     hold_req = 1'b0;
    bit     hold_active = 1'b0;
    longint cycle_count = 0;

    logistic_neuron_batch_trainer_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .feature_a     (feature_a),
        .feature_b     (feature_b),
        .target        (target),
        .last_of_epoch (last_of_epoch),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .weight_a_out  (weight_a_out),
        .weight_b_out  (weight_b_out),
        .bias_out      (bias_out),
        .error_total   (error_total),
        .samples_seen  (samples_seen),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    epoch_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .feature_a     (feature_a),
        .feature_b     (feature_b),
        .target        (target),
        .last_of_epoch (last_of_epoch),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .weight_a_out  (weight_a_out),
        .weight_b_out  (weight_b_out),
        .bias_out      (bias_out),
        .error_total   (error_total),
        .samples_seen  (samples_seen),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .errors        (failures),
        .epochs_open   (epochs_open)
    );

    always
    begin
        #CLOCK_HALF;
        clk = 1'b1;
        #CLOCK_HALF;
        clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("logistic_neuron_batch_trainer_unit test failed");
            $finish;
        end
    end

    function automatic logic signed [IN_W-1:0] random_feature();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       return 16'sh8000;
                    1:       return 16'sh7FFF;
                    2:       return 16'sh0000;
                    default: return 16'shFFFF;
                endcase
            end
            1, 2, 3: return IN_W'($urandom);
            default: return IN_W'($urandom_range(0, 8192) - 4096);
        endcase
    endfunction

    function automatic logic signed [IN_W-1:0] random_target();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return ($urandom_range(0, 1) == 1) ? 16'sh1000 : 16'sh0000;
            6, 7:             return IN_W'($urandom_range(0, 4096));
            8:                return IN_W'($urandom);
            default:          return ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
        endcase
    endfunction

    function automatic logic [W_W-1:0] random_weight();
        case ($urandom_range(0, 7))
            0:       return ($urandom_range(0, 1) == 1) ? 32'h7FFFFFFF : 32'h80000000;
            1:       return $urandom;
            default: return W_W'($urandom_range(0, 1 << 20) - (1 << 19));
        endcase
    endfunction

    function automatic logic [RATE_W-1:0] random_rate();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return RATE_W'($urandom);
            default: return RATE_W'($urandom_range(64, 8192));
        endcase
    endfunction

    task automatic push_word(input logic op, input logic signed [IN_W-1:0] fa,
                             input logic signed [IN_W-1:0] fb,
                             input logic signed [IN_W-1:0] tg, input logic last);
        in_valid <= 1'b1;
        opcode <= op;
        feature_a <= fa;
        feature_b <= fb;
        target <= tg;
        last_of_epoch <= last;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        words_sent++;
        if (gap_max > 0)
        begin
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                burst_left = $urandom_range(0, 24);
                in_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max))
                begin
                    @(posedge clk);
                end
            end
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (epochs_open != 0);
        repeat (SETTLE_CYCLES)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input cfg_reg_t which, input logic [W_W-1:0] value);
        cfg_wen <= 1'b1;
        cfg_index <= which;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    task automatic set_registers(input logic [RATE_W-1:0] rate, input logic [W_W-1:0] wa,
                                 input logic [W_W-1:0] wb, input logic [W_W-1:0] bias);
        write_reg(CFG_LEARN_RATE, {16'd0, rate});
        write_reg(CFG_INIT_WEIGHT_A, wa);
        write_reg(CFG_INIT_WEIGHT_B, wb);
        write_reg(CFG_INIT_BIAS, bias);
        cfg_wen <= 1'b0;
    endtask

    initial
    begin : receiver_pattern
        int mode;
        int span;
        int i;
        forever
        begin
            if (hold_req && !hold_active)
            begin
                hold_active <= 1'b1;
                repeat (HOLD_CYCLES)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 120);
            for (i = 0; i < span; i++)
            begin
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ((i / 6) % 2 == 1);
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int   phase;
        int   epochs;
        int   len;
        int   i;
        int   j;
        int   k;
        logic last;
        repeat (RESET_CYCLES)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        push_word(OP_TRAIN, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0);
        push_word(OP_TRAIN, 16'sh8000, 16'sh7FFF, 16'sh8000, 1'b0);
        push_word(OP_TRAIN, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1);
        push_word(OP_TRAIN, 16'sh1000, 16'sh1000, 16'sh1000, 1'b1);
        push_word(OP_LOAD, 16'shFFFF, 16'shFFFF, 16'shFFFF, 1'b1);
        push_word(OP_TRAIN, 16'sh03E8, 16'shFC18, 16'sh0000, 1'b0);
        push_word(OP_LOAD, 16'sh1234, 16'sh4321, 16'sh0800, 1'b0);
        push_word(OP_TRAIN, 16'sh7FFF, 16'sh7FFF, 16'sh0000, 1'b1);
        settle();

        set_registers(16'hFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        push_word(OP_LOAD, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
        push_word(OP_TRAIN, 16'sh7FFF, 16'sh0000, 16'sh8000, 1'b0);
        push_word(OP_TRAIN, 16'sh0000, 16'sh7FFF, 16'sh7FFF, 1'b1);
        push_word(OP_TRAIN, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
        settle();

        // With a zero rate the committed weights must come back unchanged.
        set_registers(16'h0000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        push_word(OP_LOAD, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
        push_word(OP_TRAIN, 16'sh2000, 16'shE000, 16'sh1000, 1'b0);
        push_word(OP_TRAIN, 16'sh8000, 16'sh7FFF, 16'sh0000, 1'b1);
        settle();

        // A bias of exactly -8.0 and then +8.0 puts the sum on both table edges.
        set_registers(16'd655, 32'h00000000, 32'h00000000, 32'hFFF80000);
        push_word(OP_LOAD, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
        push_word(OP_TRAIN, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
        push_word(OP_TRAIN, 16'sh1000, 16'sh1000, 16'sh1000, 1'b1);
        settle();
        set_registers(16'd655, 32'h00000000, 32'h00000000, 32'h00080000);
        push_word(OP_LOAD, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
        push_word(OP_TRAIN, 16'sh0000, 16'sh0000, 16'sh1000, 1'b1);

        words_sent = 0;
        phase = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            settle();
            set_registers(random_rate(), random_weight(), random_weight(), random_weight());
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 14));
            burst_left = 0;
            if (phase == HOLD_PHASE)
            begin
                // Short epochs against a blocked output fill the block until it stalls its input.
                hold_req <= 1'b1;
                do
                    @(posedge clk);
                while (!hold_active);
                gap_max = 0;
                push_word(OP_LOAD, random_feature(), random_feature(), random_target(), 1'b0);
                for (i = 0; i < HOLD_WORDS; i++)
                begin
                    push_word(OP_TRAIN, random_feature(), random_feature(), random_target(),
                              1'($urandom_range(0, 1)));
                end
            end
            else
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    push_word(OP_LOAD, random_feature(), random_feature(), random_target(),
                              1'($urandom_range(0, 1)));
                end
                epochs = $urandom_range(1, 6);
                for (k = 0; k < epochs; k++)
                begin
                    len = ($urandom_range(0, 7) == 0) ? int'($urandom_range(9, 30))
                                                      : int'($urandom_range(1, 8));
                    for (j = 0; j < len; j++)
                    begin
                        if ($urandom_range(0, 39) == 0)
                        begin
                            push_word(OP_LOAD, random_feature(), random_feature(),
                                      random_target(), 1'($urandom_range(0, 1)));
                        end
                        last = (j == len - 1) && ($urandom_range(0, 9) != 0);
                        push_word(OP_TRAIN, random_feature(), random_feature(), random_target(),
                                  last);
                    end
                end
            end
            phase++;
        end
        settle();

        if (failures == 0)
        begin
            $display("logistic_neuron_batch_trainer_unit test passed");
        end
        else
        begin
            $display("logistic_neuron_batch_trainer_unit test failed");
        end
        $finish;
    end

endmodule

// ===== logistic_neuron_batch_trainer_unit.f =====
rtl/lnbt_pkg.sv
rtl/lnbt_lane.sv
rtl/lnbt_merge.sv
rtl/logistic_neuron_batch_trainer_unit.sv
rtl/lnbt_checker.sv
dv/epoch_checker.sv
dv/tb_top.sv
